@@ rtl/core/wildcard_byte_pattern_search_assert.svh @@
// Assertion macros used by the pattern search RTL.
`ifndef WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH
`define WILDCARD_BYTE_PATTERN_SEARCH_ASSERT_SVH

// Checked only while out of reset.
`define WBPS_CHECK(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Checked at every edge, reset included.
`define WBPS_CHECK_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ rtl/core/wbps_pkg.sv @@
// Shared types and constants of the wildcard byte pattern search.
`timescale 1ns / 1ps

package wbps_pkg;

    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 32;
    localparam int MASK_W     = 16;
    localparam int LEN_CFG_W  = 5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;
    localparam int OUT_DATA_W = 40;
    // Pattern positions with a stored byte and care bit; later ones are wildcards.
    localparam int PAT_STORED = 16;

    typedef logic [BYTE_W-1:0]    byte_t;
    typedef logic [COUNT_W-1:0]   count_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    localparam count_t COUNT_TOP = '1;

    localparam cfg_index_t REG_PATTERN_LOW     = 3'd0;
    localparam cfg_index_t REG_PATTERN_HIGH    = 3'd1;
    localparam cfg_index_t REG_CARE_MASK       = 3'd2;
    localparam cfg_index_t REG_PATTERN_LENGTH  = 3'd3;
    localparam cfg_index_t REG_EXPECTED_OFFSET = 3'd4;

    // Control for the window cells.
    typedef struct packed {
        logic advance;
        logic clear;
    } shift_ctl_t;

    // Per-word status from the cell row to the match tracker.
    typedef struct packed {
        logic advance;
        logic last;
        logic window_match;
    } scan_ctl_t;

endpackage

@@ rtl/core/wbps_cell.sv @@
// One window cell: holds a stream byte and compares the byte it takes next.
`timescale 1ns / 1ps

module wbps_cell (
    input  logic                 aclk,
    input  wbps_pkg::shift_ctl_t ctl,
    input  wbps_pkg::byte_t      shift_in,
    input  wbps_pkg::byte_t      pat_byte,
    input  logic                 care,
    output wbps_pkg::byte_t      byte_q,
    output logic                 hit
);

    wbps_pkg::byte_t byte_reg;
    wbps_pkg::byte_t byte_next;

    // Judged on the window as it stands after this word is shifted in.
    assign hit = !care || (shift_in == pat_byte);

    always_comb begin
        byte_next = byte_reg;
        if (ctl.advance) begin
            byte_next = ctl.clear ? '0 : shift_in;
        end
    end

    always_ff @(posedge aclk) begin
        byte_reg <= byte_next;
    end

    assign byte_q = byte_reg;

endmodule

@@ rtl/core/wbps_tracker.sv @@
// Byte counter, hit bookkeeping and result register of the pattern search.
`timescale 1ns / 1ps
`include "wildcard_byte_pattern_search_assert.svh"

module wbps_tracker (
    input  logic                aclk,
    input  logic                aresetn,
    input  wbps_pkg::scan_ctl_t ctl,
    input  wbps_pkg::count_t    used_len,
    input  wbps_pkg::count_t    expected_offset,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    output logic                out_found,
    output wbps_pkg::count_t    out_offset,
    output logic                out_at_expected
);

    wbps_pkg::count_t count_reg, count_next;
    logic             first_seen_reg, first_seen_next;
    wbps_pkg::count_t first_off_reg, first_off_next;
    logic             exp_hit_reg, exp_hit_next;
    logic             out_valid_reg, out_valid_next;
    logic             found_reg, found_next;
    wbps_pkg::count_t offset_reg, offset_next;
    logic             at_exp_reg, at_exp_next;

    wbps_pkg::count_t received;
    wbps_pkg::count_t start;
    logic             hit;
    logic             first_seen_now;
    wbps_pkg::count_t first_off_now;
    logic             exp_hit_now;

    // Only a last word needs the result slot; other words pass a waiting result.
    assign in_ready = !out_valid_reg || out_ready || !ctl.last;

    always_comb begin
        received       = count_reg + 1'b1;
        start          = received - used_len;
        // A saturated count ends no window.
        hit            = (count_reg != wbps_pkg::COUNT_TOP) && (used_len != '0)
                         && (received >= used_len) && ctl.window_match;
        first_seen_now = first_seen_reg || hit;
        first_off_now  = first_seen_reg ? first_off_reg : start;
        exp_hit_now    = exp_hit_reg || (hit && (start == expected_offset));
    end

    always_comb begin
        count_next      = count_reg;
        first_seen_next = first_seen_reg;
        first_off_next  = first_off_reg;
        exp_hit_next    = exp_hit_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        found_next      = found_reg;
        offset_next     = offset_reg;
        at_exp_next     = at_exp_reg;
        if (ctl.advance) begin
            if (ctl.last) begin
                count_next      = '0;
                first_seen_next = 1'b0;
                first_off_next  = '0;
                exp_hit_next    = 1'b0;
                out_valid_next  = 1'b1;
                priority if (used_len == '0 || exp_hit_now) begin
                    found_next  = 1'b1;
                    offset_next = expected_offset;
                    at_exp_next = 1'b1;
                end else if (first_seen_now) begin
                    found_next  = 1'b1;
                    offset_next = first_off_now;
                    at_exp_next = 1'b0;
                end else begin
                    found_next  = 1'b0;
                    offset_next = '0;
                    at_exp_next = 1'b0;
                end
            end else begin
                if (count_reg != wbps_pkg::COUNT_TOP) begin
                    count_next = received;
                end
                first_seen_next = first_seen_now;
                first_off_next  = first_off_now;
                exp_hit_next    = exp_hit_now;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            first_seen_reg <= 1'b0;
            first_off_reg  <= '0;
            exp_hit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            count_reg      <= count_next;
            first_seen_reg <= first_seen_next;
            first_off_reg  <= first_off_next;
            exp_hit_reg    <= exp_hit_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        found_reg  <= found_next;
        offset_reg <= offset_next;
        at_exp_reg <= at_exp_next;
    end

    assign out_valid       = out_valid_reg;
    assign out_found       = found_reg;
    assign out_offset      = offset_reg;
    assign out_at_expected = at_exp_reg;

    `WBPS_CHECK_RST(a_reset_clears, (!aresetn) |=> (!out_valid_reg && count_reg == '0), "reset left state")
    `WBPS_CHECK(a_count_saturates, (ctl.advance && !ctl.last && count_reg == wbps_pkg::COUNT_TOP) |=> (count_reg == wbps_pkg::COUNT_TOP), "byte count wrapped")
    `WBPS_CHECK(a_image_end_clears, (ctl.advance && ctl.last) |=> (count_reg == '0 && !first_seen_reg && !exp_hit_reg && out_valid_reg), "image end did not restart scan")
    `WBPS_CHECK(a_not_found_zero, (out_valid_reg && !found_reg) |-> (offset_reg == '0 && !at_exp_reg), "not-found result carries data")

endmodule

@@ rtl/core/wildcard_byte_pattern_search.sv @@
// Top level of the wildcard byte pattern search.
`timescale 1ns / 1ps

// Scans an image streamed one byte per word on s_ and, on the word marked
// with s_tlast, gives one result word on m_. The block takes one byte every
// cycle; only a word with s_tlast waits, and only while the previous result
// still sits unaccepted on m_. The result appears in the cycle after the
// last byte is accepted. The rate is set by a row of PATTERN_MAX byte cells
// that shift the window by one byte per word and all compare against the
// pattern in that same cycle. A match at the expected offset wins;
// otherwise the first match in the image is reported, or not-found. Pattern
// length zero reports the expected offset. The user writes configuration
// through cfg_ only while no image is in flight; the block does not check.

module wildcard_byte_pattern_search #(
    parameter int PATTERN_MAX = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [7:0]                           s_tdata,   // [7:0] image_byte
    input  logic                                 s_tlast,   // last_byte
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // [0] found, [32:1] match_offset, [33] at_expected, [39:34] zero
    output logic [wbps_pkg::OUT_DATA_W-1:0]      m_tdata,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  wbps_pkg::cfg_index_t                 cfg_index,
    input  logic [wbps_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int LEN_W = $clog2(PATTERN_MAX + 1);

    logic [wbps_pkg::CFG_DATA_W-1:0] pattern_low_reg, pattern_low_next;
    logic [wbps_pkg::CFG_DATA_W-1:0] pattern_high_reg, pattern_high_next;
    logic [wbps_pkg::MASK_W-1:0]     care_mask_reg, care_mask_next;
    logic [wbps_pkg::LEN_CFG_W-1:0]  pattern_length_reg, pattern_length_next;
    wbps_pkg::count_t                expected_offset_reg, expected_offset_next;

    wbps_pkg::byte_t     pat_bytes [wbps_pkg::PAT_STORED];
    logic [LEN_W-1:0]    used_len;
    wbps_pkg::byte_t     cell_pat  [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_care;
    wbps_pkg::byte_t     cell_in   [PATTERN_MAX];
    wbps_pkg::byte_t     cell_q    [PATTERN_MAX];
    logic [PATTERN_MAX-1:0] cell_hit;

    wbps_pkg::shift_ctl_t shift_ctl;
    wbps_pkg::scan_ctl_t  scan_ctl;

    logic             found;
    wbps_pkg::count_t match_offset;
    logic             at_expected;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_comb begin
        pattern_low_next     = pattern_low_reg;
        pattern_high_next    = pattern_high_reg;
        care_mask_next       = care_mask_reg;
        pattern_length_next  = pattern_length_reg;
        expected_offset_next = expected_offset_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                wbps_pkg::REG_PATTERN_LOW:     pattern_low_next = cfg_data;
                wbps_pkg::REG_PATTERN_HIGH:    pattern_high_next = cfg_data;
                wbps_pkg::REG_CARE_MASK:       care_mask_next = cfg_data[wbps_pkg::MASK_W-1:0];
                wbps_pkg::REG_PATTERN_LENGTH:
                    pattern_length_next = cfg_data[wbps_pkg::LEN_CFG_W-1:0];
                wbps_pkg::REG_EXPECTED_OFFSET:
                    expected_offset_next = cfg_data[wbps_pkg::COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pattern_low_reg     <= '0;
            pattern_high_reg    <= '0;
            care_mask_reg       <= '0;
            pattern_length_reg  <= '0;
            expected_offset_reg <= '0;
        end else begin
            pattern_low_reg     <= pattern_low_next;
            pattern_high_reg    <= pattern_high_next;
            care_mask_reg       <= care_mask_next;
            pattern_length_reg  <= pattern_length_next;
            expected_offset_reg <= expected_offset_next;
        end
    end

    // Pattern alignment: the newest used_len cells line up with pattern bytes
    always_comb begin
        for (int i = 0; i < wbps_pkg::PAT_STORED / 2; i++) begin
            pat_bytes[i]     = pattern_low_reg[i*wbps_pkg::BYTE_W +: wbps_pkg::BYTE_W];
            pat_bytes[i + 8] = pattern_high_reg[i*wbps_pkg::BYTE_W +: wbps_pkg::BYTE_W];
        end
    end

    always_comb begin
        if (int'(pattern_length_reg) > PATTERN_MAX) begin
            used_len = LEN_W'(PATTERN_MAX);
        end else begin
            used_len = LEN_W'(pattern_length_reg);
        end
    end

    always_comb begin
        automatic int idx;
        for (int j = 0; j < PATTERN_MAX; j++) begin
            idx = j + int'(used_len) - PATTERN_MAX;
            if (idx >= 0 && idx < wbps_pkg::PAT_STORED) begin
                cell_care[j] = care_mask_reg[idx[3:0]];
                cell_pat[j]  = pat_bytes[idx[3:0]];
            end else begin
                cell_care[j] = 1'b0;
                cell_pat[j]  = '0;
            end
        end
    end

    // Cell row: the newest byte enters at the top cell and moves down
    assign shift_ctl.advance = s_tvalid && s_tready;
    assign shift_ctl.clear   = s_tlast;

    for (genvar j = 0; j < PATTERN_MAX; j++) begin : g_cell
        if (j == PATTERN_MAX - 1) begin : g_top
            assign cell_in[j] = s_tdata;
        end else begin : g_mid
            assign cell_in[j] = cell_q[j+1];
        end

        wbps_cell u_cell (
            .aclk     (aclk),
            .ctl      (shift_ctl),
            .shift_in (cell_in[j]),
            .pat_byte (cell_pat[j]),
            .care     (cell_care[j]),
            .byte_q   (cell_q[j]),
            .hit      (cell_hit[j])
        );
    end

    assign scan_ctl.advance      = shift_ctl.advance;
    assign scan_ctl.last         = s_tlast;
    assign scan_ctl.window_match = &cell_hit;

    wbps_tracker u_tracker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .ctl             (scan_ctl),
        .used_len        (wbps_pkg::COUNT_W'(used_len)),
        .expected_offset (expected_offset_reg),
        .in_ready        (s_tready),
        .out_valid       (m_tvalid),
        .out_ready       (m_tready),
        .out_found       (found),
        .out_offset      (match_offset),
        .out_at_expected (at_expected)
    );

    assign m_tdata = {6'b0, at_expected, match_offset, found};

endmodule

@@ sim/wildcard_byte_pattern_search_tb.sv @@
// Self-checking testbench for the wildcard byte pattern search top level.
`timescale 1ns / 1ps

module wildcard_byte_pattern_search_tb;

    localparam int WIN_BYTES   = 16;
    localparam int STALL_LIMIT = 3000;
    localparam int HOLD_CYCLES = 400;

    typedef struct packed {
        logic             found;
        wbps_pkg::count_t offset;
        logic             at_expected;
    } report_t;

    typedef struct packed {
        wbps_pkg::byte_t data;
        logic            last;
    } img_word_t;

    logic                            aclk      = 1'b0;
    logic                            aresetn   = 1'b0;
    logic                            s_tvalid  = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata   = '0;    // [7:0] image_byte
    logic                            s_tlast   = 1'b0;  // last_byte
    logic                            m_tvalid;
    logic                            m_tready  = 1'b0;
    // [0] found, [32:1] match_offset, [33] at_expected
    logic [wbps_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    wbps_pkg::cfg_index_t            cfg_index = wbps_pkg::REG_PATTERN_LOW;
    logic [wbps_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    // Register shadow used by the predictor
    logic [63:0]                    pat_lo  = '0;
    logic [63:0]                    pat_hi  = '0;
    logic [wbps_pkg::MASK_W-1:0]    care    = '0;
    logic [wbps_pkg::LEN_CFG_W-1:0] pat_len = '0;
    wbps_pkg::count_t               exp_off = '0;

    // Scan state
    wbps_pkg::byte_t  window [WIN_BYTES] = '{default: '0};
    wbps_pkg::count_t byte_cnt = '0;
    logic             hit_seen = 1'b0;
    wbps_pkg::count_t hit_off  = '0;
    logic             exp_hit  = 1'b0;

    img_word_t img_words [$];
    report_t   expected_reports [$];

    int unsigned words_queued    = 0;
    int unsigned words_taken     = 0;
    int unsigned results_checked = 0;
    int unsigned cfg_writes      = 0;
    int unsigned errors          = 0;
    int unsigned quiet           = 0;
    int unsigned snd_idle_pct    = 0;
    int unsigned rcv_idle_pct    = 0;
    int unsigned hold_left       = 0;
    bit          hold_armed      = 1'b0;
    bit          hold_done       = 1'b0;
    bit          s_taken         = 1'b0;

    wildcard_byte_pattern_search u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic int unsigned eff_len();
        return (pat_len > WIN_BYTES) ? WIN_BYTES : int'(pat_len);
    endfunction

    function automatic wbps_pkg::byte_t pat_byte(int unsigned i);
        if (i < 8) return pat_lo[8*i +: 8];
        return pat_hi[8*(i-8) +: 8];
    endfunction

    // Advances the scan by one image byte; returns 1 when the byte closes an image.
    function automatic bit scan_byte(input img_word_t w, output report_t rep);
        int unsigned len;
        bit          hit;
        len = eff_len();
        rep = '0;
        for (int i = 0; i < WIN_BYTES - 1; i++) window[i] = window[i+1];
        window[WIN_BYTES-1] = w.data;
        // saturated counter: byte ends no window
        if (byte_cnt != wbps_pkg::COUNT_TOP) begin
            byte_cnt++;
            if (len > 0 && byte_cnt >= len) begin
                hit = 1'b1;
                for (int i = 0; i < len; i++) begin
                    if (care[i] && window[WIN_BYTES-len+i] != pat_byte(i)) hit = 1'b0;
                end
                if (hit) begin
                    if (!hit_seen) begin
                        hit_seen = 1'b1;
                        hit_off  = byte_cnt - len;
                    end
                    if (byte_cnt - len == exp_off) exp_hit = 1'b1;
                end
            end
        end
        if (!w.last) return 1'b0;
        if (len == 0 || exp_hit) begin
            rep = '{1'b1, exp_off, 1'b1};
        end else if (hit_seen) begin
            rep = '{1'b1, hit_off, 1'b0};
        end
        foreach (window[i]) window[i] = '0;
        byte_cnt = '0;
        hit_seen = 1'b0;
        hit_off  = '0;
        exp_hit  = 1'b0;
        return 1'b1;
    endfunction

    function automatic void check_field(string name, wbps_pkg::count_t want,
                                        wbps_pkg::count_t got);
        if (want !== got) begin
            errors++;
            $display("%0t: %s mismatch, expected 0x%0h actual 0x%0h", $time, name, want, got);
        end
    endfunction

    task automatic send_image(input wbps_pkg::byte_t bytes [$]);
        foreach (bytes[k]) begin
            img_words.insert(img_words.size(), img_word_t'{bytes[k], k == bytes.size() - 1});
        end
        words_queued += bytes.size();
    endtask

    // Random image of n bytes, with the pattern planted (wildcards left random) plants times if it fits.
    task automatic plan_image(int unsigned n, int unsigned plants);
        wbps_pkg::byte_t img [$];
        int unsigned     len;
        int unsigned     pos;
        len = eff_len();
        repeat (n) img.insert(img.size(), wbps_pkg::byte_t'($urandom));
        if (len > 0 && n >= len) begin
            repeat (plants) begin
                if (exp_off <= n - len && $urandom_range(0, 1) == 1) pos = exp_off;
                else pos = $urandom_range(0, n - len);
                for (int i = 0; i < len; i++) begin
                    if (care[i]) img[pos+i] = pat_byte(i);
                end
            end
        end
        send_image(img);
    endtask

    task automatic cfg_write(wbps_pkg::cfg_index_t idx, logic [63:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            wbps_pkg::REG_PATTERN_LOW:     pat_lo  = val;
            wbps_pkg::REG_PATTERN_HIGH:    pat_hi  = val;
            wbps_pkg::REG_CARE_MASK:       care    = val[wbps_pkg::MASK_W-1:0];
            wbps_pkg::REG_PATTERN_LENGTH:  pat_len = val[wbps_pkg::LEN_CFG_W-1:0];
            wbps_pkg::REG_EXPECTED_OFFSET: exp_off = val[wbps_pkg::COUNT_W-1:0];
            default: ;
        endcase
        cfg_writes++;
    endtask

    task automatic cfg_apply(input logic [63:0] lo, input logic [63:0] hi,
                             input logic [15:0] msk, input logic [4:0] len,
                             input wbps_pkg::count_t off);
        cfg_write(wbps_pkg::REG_PATTERN_LOW, lo);
        cfg_write(wbps_pkg::REG_PATTERN_HIGH, hi);
        cfg_write(wbps_pkg::REG_CARE_MASK, 64'(msk));
        cfg_write(wbps_pkg::REG_PATTERN_LENGTH, 64'(len));
        cfg_write(wbps_pkg::REG_EXPECTED_OFFSET, 64'(off));
        @(negedge aclk);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // Block is idle once every queued word is taken and every result is back.
    task automatic wait_idle();
        do @(negedge aclk); while (words_taken != words_queued || expected_reports.size() != 0);
        repeat (4) @(posedge aclk);
    endtask

    // Sender
    always @(negedge aclk) begin : drive_bytes
        img_word_t w;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_taken) begin
            if (img_words.size() != 0 && $urandom_range(0, 99) >= snd_idle_pct) begin
                w = img_words.pop_front();
                s_tvalid <= 1'b1;
                s_tdata  <= w.data;
                s_tlast  <= w.last;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver, with one long hold-off once armed
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_left != 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rcv_idle_pct);
        end
    end

    always @(posedge aclk) begin : watch_results
        report_t rep;
        report_t want;
        s_taken = s_tvalid && s_tready;
        if (aresetn && s_taken) begin
            words_taken++;
            if (scan_byte(img_word_t'{s_tdata, s_tlast}, rep)) begin
                expected_reports.insert(expected_reports.size(), rep);
            end
        end
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_reports.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word, expected none actual 0x%0h", $time, m_tdata);
            end else begin
                want = expected_reports.pop_front();
                check_field("found", wbps_pkg::count_t'(want.found),
                            wbps_pkg::count_t'(m_tdata[0]));
                check_field("match_offset", want.offset, m_tdata[32:1]);
                check_field("at_expected", wbps_pkg::count_t'(want.at_expected),
                            wbps_pkg::count_t'(m_tdata[33]));
                check_field("padding", '0,
                            wbps_pkg::count_t'(m_tdata[wbps_pkg::OUT_DATA_W-1:34]));
                results_checked++;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet = 0;
        end else if (++quiet >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles, %0d results outstanding",
                     $time, STALL_LIMIT, expected_reports.size());
            $display("Regression FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        wbps_pkg::byte_t  bytes [$];
        logic [4:0]       len;
        logic [15:0]      msk;
        wbps_pkg::count_t off;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset registers: zero length reports the expected offset
        bytes = '{8'h00};
        send_image(bytes);

        // Wildcard in the middle, two hits, none at the expected offset;
        // then an image shorter than the pattern
        wait_idle();
        cfg_apply(64'h0000_0000_00FF_55AA, 64'h0, 16'h0005, 5'd3, 32'd2);
        bytes = '{8'h00, 8'hAA, 8'h13, 8'hFF, 8'hAA, 8'h00, 8'hFF};
        send_image(bytes);
        bytes = '{8'hAA, 8'h55};
        send_image(bytes);

        // Zero length with the top offset
        wait_idle();
        cfg_apply('1, '1, 16'hFFFF, 5'd0, '1);
        bytes = '{8'hFF};
        send_image(bytes);

        // Single byte pattern: first hit wins, expected offset past the end
        wait_idle();
        cfg_apply(64'h0, 64'h0, 16'hFFFF, 5'd1, 32'd3);
        bytes = '{8'h00, 8'h00, 8'h00};
        send_image(bytes);

        for (int ph = 0; ph < 3; ph++) begin
            wait_idle();
            snd_idle_pct = (ph == 0) ? 32 : (ph == 1) ? 78 : 0;
            rcv_idle_pct = (ph == 0) ? 78 : (ph == 1) ? 32 : 0;
            for (int c = 0; c < 6; c++) begin
                wait_idle();
                case (c)
                    0:       len = 5'd16;
                    1:       len = 5'd0;
                    2:       len = 5'd31;
                    default: len = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(17, 31))
                                                               : 5'($urandom_range(1, 16));
                endcase
                msk = (c == 0) ? 16'hFFFF : (c == 3) ? 16'h0000 : 16'($urandom);
                off = ($urandom_range(0, 3) == 0) ? wbps_pkg::count_t'($urandom)
                                                  : wbps_pkg::count_t'($urandom_range(0, 30));
                cfg_apply({$urandom, $urandom}, {$urandom, $urandom}, msk, len, off);
                if (ph == 2 && c == 0) begin
                    // short images keep coming while the receiver holds off
                    repeat (8) plan_image($urandom_range(1, 8), $urandom_range(0, 1));
                    hold_armed = 1'b1;
                end else begin
                    repeat (2) plan_image($urandom_range(1, 40), $urandom_range(0, 2));
                end
            end
        end

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("Scanned %0d image bytes across %0d register writes and three stall mixes;",
                 words_taken, cfg_writes);
        $display("%0d result words checked, %0d mismatches.", results_checked, errors);
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
